@@ design/assert_macros.svh @@
// Assertion macros for the design files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Same check, with a caller-supplied message.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

@@ design/yuyv_pkg.sv @@
// Package for the YUYV to RGB888 converter: coefficients, widths and types.
// No dependencies; imported by every design module.
package yuyv_pkg;

    localparam int unsigned LANES      = 2;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned COEF_W     = 17;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned MAG_W      = 8;
    localparam int unsigned PROD_W     = MAG_W + COEF_W;
    localparam int unsigned QUOT_W     = PROD_W - FRAC_W;
    localparam int unsigned TERM_W     = QUOT_W + 1;
    localparam int unsigned SUM_W      = TERM_W + 1;

    // Unsigned Q1.16, ceiling of coefficient * 65536
    localparam logic [COEF_W-1:0] COEF_RV = 17'd91882;
    localparam logic [COEF_W-1:0] COEF_GU = 17'd22545;
    localparam logic [COEF_W-1:0] COEF_GV = 17'd46793;
    localparam logic [COEF_W-1:0] COEF_BU = 17'd116130;

    localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'd128;
    localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;

    typedef logic signed [TERM_W-1:0] t_term;

    typedef struct packed {
        t_term rv;
        t_term gu;
        t_term gv;
        t_term bu;
    } t_chroma_terms;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

endpackage

@@ design/yuyv_chroma.sv @@
// Chroma product stage: four truncated, signed chroma terms, registered.
// Depends on yuyv_pkg.
module yuyv_chroma
    import yuyv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [PIX_W-1:0]    i_chroma_blue,
    input  logic [PIX_W-1:0]    i_chroma_red,
    output t_chroma_terms       o_terms
);

    t_chroma_terms r_terms;
    t_chroma_terms n_terms;

    // Magnitude times coefficient, truncated, then the chroma sign restored
    function automatic t_term chroma_term(input logic [PIX_W-1:0] c,
                                          input logic [COEF_W-1:0] coef);
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [TERM_W-1:0] q;
        neg  = (c < CHROMA_BIAS);
        mag  = neg ? (CHROMA_BIAS - c) : (c - CHROMA_BIAS);
        prod = PROD_W'(mag) * PROD_W'(coef);
        q    = {1'b0, prod[PROD_W-1:FRAC_W]};
        return neg ? t_term'(-q) : t_term'(q);
    endfunction

    always_comb begin
        n_terms.rv = chroma_term(i_chroma_red,  COEF_RV);
        n_terms.gu = chroma_term(i_chroma_blue, COEF_GU);
        n_terms.gv = chroma_term(i_chroma_red,  COEF_GV);
        n_terms.bu = chroma_term(i_chroma_blue, COEF_BU);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

@@ design/yuyv_lane.sv @@
// One pixel lane: adds or subtracts the chroma terms with a luma byte and clamps to 0..255.
// Depends on yuyv_pkg.
module yuyv_lane
    import yuyv_pkg::*;
(
    input  logic [PIX_W-1:0] i_luma,
    input  t_chroma_terms    i_terms,
    output t_rgb             o_pixel
);

    typedef logic signed [SUM_W-1:0] t_sum;

    function automatic logic [PIX_W-1:0] clamp_pix(input t_sum x);
        if (x < 0) begin
            return '0;
        end else if (x > t_sum'({1'b0, PIX_MAX})) begin
            return PIX_MAX;
        end else begin
            return x[PIX_W-1:0];
        end
    endfunction

    t_sum luma_s;
    t_sum sum_r;
    t_sum sum_g;
    t_sum sum_b;

    always_comb begin
        luma_s = t_sum'({1'b0, i_luma});
        sum_r  = luma_s + t_sum'(i_terms.rv);
        sum_g  = luma_s - t_sum'(i_terms.gu) - t_sum'(i_terms.gv);
        sum_b  = luma_s + t_sum'(i_terms.bu);
        o_pixel.red   = clamp_pix(sum_r);
        o_pixel.green = clamp_pix(sum_g);
        o_pixel.blue  = clamp_pix(sum_b);
    end

endmodule

@@ design/yuyv_to_rgb888_converter_core.sv @@
// YUYV macropixel to two RGB888 pixels, BT.601 full range.
// Pipeline: the chroma multiply stage registers the accepted input, then
// lane add/clamp feeds the output register.
// Throughput: one item per cycle while m_axis_tready holds; the two-stage elastic
// pipeline moves whenever the next stage is empty or draining.
// Reset (i_rst_n low, synchronous) clears both stage valid flags.
// Depends on yuyv_pkg, yuyv_chroma, yuyv_lane and assert_macros.svh.
`include "assert_macros.svh"

module yuyv_to_rgb888_converter_core
    import yuyv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
    input  logic [31:0] s_axis_tdata,
    // last_pair
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_first[7:0], green_first[15:8], blue_first[23:16],
    // red_second[31:24], green_second[39:32], blue_second[47:40]
    output logic [47:0] m_axis_tdata,
    // frame_end
    output logic        m_axis_tlast
);

    logic               r_v1;
    logic [PIX_W-1:0]   r_luma [LANES];
    logic               r_last1;
    t_chroma_terms      terms;

    logic               r_v2;
    t_rgb               r_pix [LANES];
    logic               r_last2;

    t_rgb               lane_pix [LANES];
    logic [PIX_W-1:0]   in_luma [LANES];

    logic               s2_ready;
    logic               s1_ready;
    logic               s_fire;
    logic               adv2;

    assign s2_ready = !r_v2 || m_axis_tready;
    assign s1_ready = !r_v1 || s2_ready;
    assign s_fire   = s_axis_tvalid && s1_ready;
    assign adv2     = r_v1 && s2_ready;

    assign in_luma[0] = s_axis_tdata[7:0];
    assign in_luma[1] = s_axis_tdata[23:16];

    yuyv_chroma u_chroma (
        .i_clk         (i_clk),
        .i_en          (s_fire),
        .i_chroma_blue (s_axis_tdata[15:8]),
        .i_chroma_red  (s_axis_tdata[31:24]),
        .o_terms       (terms)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        yuyv_lane u_lane (
            .i_luma  (r_luma[g]),
            .i_terms (terms),
            .o_pixel (lane_pix[g])
        );

        always_ff @(posedge i_clk) begin
            if (s_fire) begin
                r_luma[g] <= in_luma[g];
            end
            if (adv2) begin
                r_pix[g] <= lane_pix[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_last1 <= s_axis_tlast;
        end
        if (adv2) begin
            r_last2 <= r_last1;
        end
    end

    // Merge: pixel pair packed red, green, blue per pixel, first pixel low
    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {r_pix[1].blue, r_pix[1].green, r_pix[1].red,
                            r_pix[0].blue, r_pix[0].green, r_pix[0].red};
    assign m_axis_tlast  = r_last2;

    // Input stalls only when both stages are full and the output is blocked
    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n,
        !s_axis_tready |-> (r_v1 && r_v2 && !m_axis_tready))
    // A held item moves on into an empty output register
    `ASSERT_CLK(a_stage_moves, i_clk, i_rst_n,
        (r_v1 && !r_v2) |=> r_v2)
    // Neutral chroma gives zero terms
    `ASSERT_CLK_MSG(a_neutral_chroma, i_clk, i_rst_n,
        (s_fire && s_axis_tdata[15:8] == CHROMA_BIAS &&
         s_axis_tdata[31:24] == CHROMA_BIAS) |=>
        (terms.rv == 0 && terms.gu == 0 && terms.gv == 0 && terms.bu == 0),
        "neutral chroma produced a nonzero term")

endmodule
